@@ design/dfwd_pkg.sv @@
// Shared types, codes and helpers for the detector fragment word decoder.
// No dependencies; imported by every module of the block.
package dfwd_pkg;

   localparam int CHANNEL_COUNT = 4096;
   localparam int NUM_FIELDS = 32;
   localparam int FID_W = 5;

   // Configuration register indexes
   localparam logic REG_WAVEFORM_ENABLE = 1'b0;

   // Packet types, word bits 31..28
   localparam logic [3:0] PT_HEADER   = 4'h8;
   localparam logic [3:0] PT_TRIGGER  = 4'h9;
   localparam logic [3:0] PT_TS_LOW   = 4'hA;
   localparam logic [3:0] PT_TS_HIGH  = 4'hB;
   localparam logic [3:0] PT_WAVE     = 4'hC;
   localparam logic [3:0] PT_NETWORK  = 4'hD;
   localparam logic [3:0] PT_TRAILER  = 4'hE;
   localparam logic [3:0] PT_UNASSIGN = 4'hF;

   // Result kinds
   localparam logic [1:0] KIND_FIELD  = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ABORT  = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_TYPE   = 2'd1;
   localparam logic [1:0] ERR_NO_TRAILER = 2'd2;

   // Record field indexes
   localparam int F_DTYPE = 0;
   localparam int F_ADDR = 1;
   localparam int F_CHAN = 2;
   localparam int F_WFP = 3;
   localparam int F_PILEUP = 4;
   localparam int F_MASTER = 5;
   localparam int F_TREQ = 6;
   localparam int F_TS = 7;
   localparam int F_DEAD = 8;
   localparam int F_NET = 9;
   localparam int F_TACC = 10;
   localparam int F_E1 = 11;
   localparam int F_EBAD = 12;
   localparam int F_INTEG = 13;
   localparam int F_NHIT = 14;
   localparam int F_CFD = 15;
   localparam int F_INTEG2 = 16;
   localparam int F_E2 = 17;
   localparam int F_E2BAD = 18;
   localparam int F_CCL = 19;
   localparam int F_CCS = 20;
   localparam int F_INTEG3 = 21;
   localparam int F_INTEG4 = 22;
   localparam int F_E3 = 23;
   localparam int F_E4BAD = 24;
   localparam int F_E4 = 25;
   localparam int F_WLEN = 26;
   localparam int F_BADFIRST = 27;
   localparam int F_HDRLATE = 28;
   localparam int F_WAVENOHDR = 29;
   localparam int F_EXCESS = 30;
   localparam int F_MISMATCH = 31;

   typedef struct packed {
      logic [31:0] word;
      logic        bank_last;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FID_W-1:0]   field_id;
      logic [15:0]        sample_index;
      logic signed [63:0] field_value;
      logic [1:0]         error_code;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_ABORT,
      JOB_SAMPLE,
      JOB_DUMP
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   err;
      logic [15:0]  sidx;
      logic [15:0]  s0;
      logic [15:0]  s1;
   } job_type;

   typedef logic [63:0] record_type [NUM_FIELDS];

   function automatic logic [63:0] sx32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

endpackage

@@ design/dfwd_queue.sv @@
// Four-entry job queue between decoder front and result back end.
// Depends on dfwd_pkg for the job type.
module dfwd_queue
   import dfwd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type head,
   output logic    full,
   output logic    empty
);

   job_type    mem_ff [4];
   logic [1:0] wptr_ff, wptr_in;
   logic [1:0] rptr_ff, rptr_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      wptr_in = push ? wptr_ff + 2'd1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 2'd1 : rptr_ff;
      count_in = count_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign head = mem_ff[rptr_ff];
   assign full = (count_ff == 3'd4);
   assign empty = (count_ff == 3'd0);

endmodule

@@ design/dfwd_front.sv @@
// Decoder front: accepts readout words, builds the open fragment record
// and queues result jobs. Depends on dfwd_pkg.
module dfwd_front
   import dfwd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req,
   input  logic       waveform_enable,
   output logic       job_push,
   output job_type    job_data,
   output logic       snap_load,
   output record_type snap_data
);

   record_type  record_ff;
   record_type  record_in;
   record_type  rec_upd;
   logic [2:0]  wp_ff, wp_in;
   logic [1:0]  pend_ff, pend_in;
   logic [3:0]  pwc_ff, pwc_in;
   logic        hdr_ff, hdr_in;
   logic [15:0] sc_ff, sc_in;
   logic        disc_ff, disc_in;

   logic [31:0] w;
   logic [3:0]  ptype;
   logic [27:0] value;
   logic [13:0] ch_sum;
   logic [31:0] x;
   logic        d6;
   logic        do_clear;
   logic        set_disc;
   logic        push_c;
   logic        dump_c;
   job_type     job_c;

   assign w = req.word;
   assign ptype = w[31:28];
   assign value = w[27:0];
   assign ch_sum = {6'b0, value[11:4]} + {6'b0, value[15:12], 4'b0}
                 + {2'b0, value[19:16], 8'b0};
   assign d6 = (record_ff[F_DTYPE] == 64'd6);
   assign x = (d6 && w[29]) ? {2'b11, w[29:0]} : w;

   always_comb begin
      rec_upd = record_ff;
      wp_in = wp_ff;
      pend_in = pend_ff;
      pwc_in = pwc_ff;
      hdr_in = hdr_ff;
      sc_in = sc_ff;
      disc_in = disc_ff;
      do_clear = 1'b0;
      set_disc = 1'b0;
      push_c = 1'b0;
      dump_c = 1'b0;
      job_c = '0;
      if (disc_ff) begin
         if (ptype == PT_TRAILER || req.bank_last) begin
            do_clear = 1'b1;
         end
      end else if (req.bank_last && ptype != PT_TRAILER) begin
         push_c = 1'b1;
         job_c.kind = JOB_ABORT;
         job_c.err = (ptype == PT_UNASSIGN) ? ERR_BAD_TYPE : ERR_NO_TRAILER;
         do_clear = 1'b1;
      end else begin
         if (wp_ff != 3'd7) begin
            wp_in = wp_ff + 3'd1;
         end
         if (wp_ff == 3'd0 && !w[31]) begin
            rec_upd[F_BADFIRST] = 64'd1;
         end
         if (pend_ff != 2'd0 && !w[31]) begin
            if (pend_ff == 2'd2) begin
               rec_upd[F_WFP] = {63'b0, w[15]};
               rec_upd[F_PILEUP] = {59'b0, w[4:0]};
            end else begin
               rec_upd[F_MASTER] = {32'b0, w};
            end
            pend_in = pend_ff - 2'd1;
         end else begin
            pend_in = 2'd0;
            case (ptype)
               PT_HEADER: begin
                  if (wp_ff != 3'd0) begin
                     rec_upd[F_HDRLATE] = 64'd1;
                  end
                  rec_upd[F_DTYPE] = {60'b0, value[3:0]};
                  rec_upd[F_ADDR] = {48'b0, value[19:4]};
                  if (ch_sum >= 14'(CHANNEL_COUNT)) begin
                     rec_upd[F_CHAN] = {50'b0, 14'(CHANNEL_COUNT - 1)};
                  end else begin
                     rec_upd[F_CHAN] = {50'b0, ch_sum};
                  end
                  pwc_in = 4'd0;
                  hdr_in = 1'b1;
                  pend_in = 2'd2;
               end
               PT_TRIGGER: rec_upd[F_TREQ] = {36'b0, value};
               PT_TS_LOW: begin
                  if (record_ff[F_TS] == 64'd0) begin
                     rec_upd[F_TS] = {36'b0, value};
                  end
               end
               PT_TS_HIGH: begin
                  rec_upd[F_TS] = record_ff[F_TS] | {22'b0, value[13:0], 28'b0};
                  rec_upd[F_DEAD] = {50'b0, value[27:14]};
               end
               PT_WAVE: begin
                  if (!hdr_ff) begin
                     rec_upd[F_WAVENOHDR] = 64'd1;
                  end else if (waveform_enable) begin
                     push_c = 1'b1;
                     job_c.kind = JOB_SAMPLE;
                     job_c.sidx = sc_ff;
                     job_c.s0 = {{2{value[13]}}, value[13:0]};
                     job_c.s1 = {{2{value[27]}}, value[27:14]};
                     sc_in = sc_ff + 16'd2;
                     rec_upd[F_WLEN] = {48'b0, sc_in};
                  end
               end
               PT_NETWORK: begin
                  rec_upd[F_NET] = sx32(w);
                  pend_in = 2'd2;
               end
               PT_TRAILER: begin
                  rec_upd[F_TACC] = {50'b0, w[27:14]};
                  if (w[13:0] != record_ff[F_TREQ][13:0]
                      && record_ff[F_DTYPE] != 64'd15) begin
                     rec_upd[F_MISMATCH] = 64'd1;
                  end
                  push_c = 1'b1;
                  dump_c = 1'b1;
                  job_c.kind = JOB_DUMP;
                  do_clear = 1'b1;
               end
               PT_UNASSIGN: begin
                  push_c = 1'b1;
                  job_c.kind = JOB_ABORT;
                  job_c.err = ERR_BAD_TYPE;
                  do_clear = 1'b1;
                  set_disc = 1'b1;
               end
               default: begin
                  if (wp_ff < 3'd3) begin
                     rec_upd[F_WFP] = {63'b0, w[15]};
                     rec_upd[F_PILEUP] = {59'b0, w[4:0]};
                     pend_in = 2'd1;
                  end else begin
                     pwc_in = (pwc_ff == 4'd8) ? 4'd8 : pwc_ff + 4'd1;
                     case (pwc_in)
                        4'd1: begin
                           rec_upd[F_E1] = d6 ? sx32(x) : {39'b0, w[24:0]};
                           rec_upd[F_EBAD] = {63'b0, w[25]};
                           rec_upd[F_INTEG] = record_ff[F_INTEG]
                                            | {50'b0, x[30:26], 9'b0};
                           rec_upd[F_NHIT] = 64'd1;
                        end
                        4'd2: begin
                           rec_upd[F_CFD] = d6 ? sx32(x) : {42'b0, w[21:0]};
                           rec_upd[F_INTEG] = record_ff[F_INTEG]
                                            | {55'b0, x[30:22]};
                        end
                        4'd3: begin
                           if (d6) begin
                              rec_upd[F_CCL] = sx32(x);
                           end else begin
                              rec_upd[F_INTEG2] = {50'b0, w[13:0]};
                              rec_upd[F_NHIT] = {56'b0, w[23:16]};
                           end
                        end
                        4'd4: begin
                           if (d6) begin
                              rec_upd[F_CCS] = sx32(x);
                           end else begin
                              rec_upd[F_E2] = {42'b0, w[21:0]};
                              rec_upd[F_E2BAD] = {63'b0, w[25]};
                           end
                        end
                        4'd5: begin
                           rec_upd[F_INTEG3] = {50'b0, w[13:0]};
                           rec_upd[F_INTEG4] = {50'b0, w[29:16]};
                        end
                        4'd6: begin
                           rec_upd[F_E3] = {42'b0, w[21:0]};
                           rec_upd[F_E4BAD] = {63'b0, w[25]};
                        end
                        4'd7: begin
                           rec_upd[F_E4] = {42'b0, w[21:0]};
                           rec_upd[F_E4BAD] = {63'b0, w[25]};
                        end
                        default: rec_upd[F_EXCESS] = 64'd1;
                     endcase
                  end
               end
            endcase
         end
      end

      record_in = rec_upd;
      if (do_clear) begin
         for (int i = 0; i < NUM_FIELDS; i++) begin
            record_in[i] = 64'd0;
         end
         record_in[F_MASTER] = '1;
         wp_in = 3'd0;
         pend_in = 2'd0;
         pwc_in = 4'd0;
         hdr_in = 1'b0;
         sc_in = 16'd0;
         disc_in = set_disc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FIELDS; i++) begin
            record_ff[i] <= 64'd0;
         end
         record_ff[F_MASTER] <= '1;
         wp_ff <= '0;
         pend_ff <= '0;
         pwc_ff <= '0;
         hdr_ff <= 1'b0;
         sc_ff <= '0;
         disc_ff <= 1'b0;
      end else if (accept) begin
         record_ff <= record_in;
         wp_ff <= wp_in;
         pend_ff <= pend_in;
         pwc_ff <= pwc_in;
         hdr_ff <= hdr_in;
         sc_ff <= sc_in;
         disc_ff <= disc_in;
      end
   end

   assign job_push = accept && push_c;
   assign job_data = job_c;
   assign snap_load = accept && dump_c;
   assign snap_data = rec_upd;

endmodule

@@ design/dfwd_back.sv @@
// Result back end: takes queued jobs, holds the trailer snapshot and
// drives the result channel through an output register. Depends on dfwd_pkg.
module dfwd_back
   import dfwd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       snap_load,
   input  record_type snap_data,
   output logic       snap_busy,
   input  job_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload
);

   record_type       snap_ff;
   logic             busy_ff, busy_in;
   logic [FID_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   rsp_type          out_ff, out_in;
   logic             load;
   logic             final_c;
   logic [15:0]      smp;

   assign load = !empty && (!valid_ff || rsp_ready);
   assign smp = cnt_ff[0] ? head.s1 : head.s0;

   always_comb begin
      out_in = '0;
      final_c = 1'b0;
      case (head.kind)
         JOB_SAMPLE: begin
            out_in.kind = KIND_SAMPLE;
            out_in.sample_index = head.sidx + {15'b0, cnt_ff[0]};
            out_in.field_value = {{48{smp[15]}}, smp};
            final_c = cnt_ff[0];
         end
         JOB_DUMP: begin
            out_in.kind = KIND_FIELD;
            out_in.field_id = cnt_ff;
            out_in.field_value = snap_ff[cnt_ff];
            final_c = (cnt_ff == FID_W'(NUM_FIELDS - 1));
         end
         default: begin
            out_in.kind = KIND_ABORT;
            out_in.error_code = head.err;
            final_c = 1'b1;
         end
      endcase
      out_in.last = final_c;
   end

   assign pop = load && final_c;

   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = final_c ? '0 : cnt_ff + 1'b1;
      end
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      busy_in = busy_ff;
      if (snap_load) begin
         busy_in = 1'b1;
      end else if (pop && head.kind == JOB_DUMP) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_ff <= snap_data;
      end
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign snap_busy = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_payload = out_ff;

   // a new trailer must never overwrite a snapshot still being sent
   a_snap_free: assert property (@(posedge clock) disable iff (reset)
      snap_load |-> !busy_ff)
      else $error("snapshot overwritten while busy");

   a_abort_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_ff.kind == KIND_ABORT |-> out_ff.last)
      else $error("abort result not marked last");

   a_dump_needs_snap: assert property (@(posedge clock) disable iff (reset)
      load && head.kind == JOB_DUMP |-> busy_ff)
      else $error("field dump without snapshot");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(out_ff))
      else $error("result dropped while stalled");

endmodule

@@ design/detector_fragment_word_decoder.sv @@
// Top level of the detector fragment word decoder: front, job queue, back end
// and the waveform enable register. Depends on dfwd_pkg and the dfwd modules.
//
// The front takes one readout word per cycle while req_ready is high and
// updates the open fragment record in the same cycle; results leave one per
// cycle from the back end while rsp_ready is high. A waveform word yields two
// results when waveform output is enabled, a trailer 32 (the record fields in
// field order, last one marked) and an abort one, so the result port sets the
// average word rate. A trailer is held off while the previous trailer's 32
// fields are still being sent, and any word is held off while the four-entry
// job queue is full. No clearing pass after reset.
module detector_fragment_word_decoder
   import dfwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic       wave_en_ff;
   logic       accept;
   logic       job_push;
   job_type    job_data;
   job_type    head;
   logic       full;
   logic       empty;
   logic       pop;
   logic       snap_load;
   record_type snap_data;
   logic       snap_busy;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_en_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr[2] == REG_WAVEFORM_ENABLE) begin
         wave_en_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == REG_WAVEFORM_ENABLE) ? {31'b0, wave_en_ff} : 32'd0;

   // hold trailers while the snapshot is still in use
   assign req_ready = !full
                    && !(snap_busy && req_payload.word[31:28] == PT_TRAILER);
   assign accept = req_valid && req_ready;

   dfwd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req             (req_payload),
      .waveform_enable (wave_en_ff),
      .job_push        (job_push),
      .job_data        (job_data),
      .snap_load       (snap_load),
      .snap_data       (snap_data)
   );

   dfwd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   dfwd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .snap_load   (snap_load),
      .snap_data   (snap_data),
      .snap_busy   (snap_busy),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ bench/tb.sv @@
// Testbench for detector_fragment_word_decoder: directed table, then random fragments.
// Depends on dfwd_pkg; checks every result against an in-bench fragment decoder.
module tb;
   import dfwd_pkg::*;

   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [31:0] word;
      logic        bank_last;
      logic [1:0]  err;   // typed abort code, ERR_NONE leaves it to the decoder model
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // decoder model state
   logic [63:0] frag_rec [NUM_FIELDS];
   logic [2:0]  word_pos;
   logic [1:0]  opt_pending;
   logic [3:0]  pulse_count;
   logic        hdr_seen;
   logic [15:0] sample_cnt;
   logic        discard;
   logic        wave_en;

   rsp_type     result_q[$];
   int          error_count;
   int          words_sent;
   logic        req_fire;
   logic [1:0]  typed_err;
   logic        calm;

   detector_fragment_word_decoder dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [63:0] sext32(input logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   task automatic report(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic clear_frag();
      foreach (frag_rec[i]) frag_rec[i] = '0;
      frag_rec[F_MASTER] = '1;
      word_pos = '0;
      opt_pending = '0;
      pulse_count = '0;
      hdr_seen = 1'b0;
      sample_cnt = '0;
      discard = 1'b0;
   endtask

   task automatic push_result(input logic [1:0] kind, input int fid, input logic [15:0] sidx,
                              input logic [63:0] val, input logic [1:0] err);
      rsp_type r;
      r.kind = kind;
      r.field_id = fid[FID_W-1:0];
      r.sample_index = sidx;
      r.field_value = val;
      r.error_code = err;
      r.last = 1'b0;
      result_q.push_back(r);
   endtask

   task automatic push_sample(input logic [13:0] raw, input logic neg);
      logic [63:0] v;
      v = {50'b0, raw};
      if (neg) v = v | 64'hFFFF_FFFF_FFFF_C000;
      push_result(KIND_SAMPLE, 0, sample_cnt, v, ERR_NONE);
      sample_cnt = sample_cnt + 16'd1;
      frag_rec[F_WLEN] = {48'b0, sample_cnt};
   endtask

   task automatic decode_pulse(input logic [31:0] w);
      logic        d6;
      logic [63:0] x;
      d6 = (frag_rec[F_DTYPE] == 64'd6);
      x = {32'b0, w};
      if (d6 && w[29]) x = x | 64'hC000_0000;
      if (pulse_count < 8) pulse_count++;
      case (pulse_count)
         4'd1: begin
            frag_rec[F_E1] = d6 ? sext32(x) : {39'b0, w[24:0]};
            frag_rec[F_EBAD] = {63'b0, w[25]};
            frag_rec[F_INTEG] = frag_rec[F_INTEG] | ((x & 64'h7c00_0000) >> 17);
            frag_rec[F_NHIT] = 64'd1;
         end
         4'd2: begin
            frag_rec[F_CFD] = d6 ? sext32(x) : {42'b0, w[21:0]};
            frag_rec[F_INTEG] = frag_rec[F_INTEG] | ((x & 64'h7FC0_0000) >> 22);
         end
         4'd3: begin
            if (d6) begin
               frag_rec[F_CCL] = sext32(x);
            end else begin
               frag_rec[F_INTEG2] = {50'b0, w[13:0]};
               frag_rec[F_NHIT] = {56'b0, w[23:16]};
            end
         end
         4'd4: begin
            if (d6) begin
               frag_rec[F_CCS] = sext32(x);
            end else begin
               frag_rec[F_E2] = {42'b0, w[21:0]};
               frag_rec[F_E2BAD] = {63'b0, w[25]};
            end
         end
         4'd5: begin
            frag_rec[F_INTEG3] = {50'b0, w[13:0]};
            frag_rec[F_INTEG4] = {50'b0, w[29:16]};
         end
         4'd6: begin
            frag_rec[F_E3] = {42'b0, w[21:0]};
            frag_rec[F_E4BAD] = {63'b0, w[25]};
         end
         4'd7: begin
            frag_rec[F_E4] = {42'b0, w[21:0]};
            frag_rec[F_E4BAD] = {63'b0, w[25]};
         end
         default: frag_rec[F_EXCESS] = 64'd1;
      endcase
   endtask

   // Work out the results of one accepted word and advance the model state.
   task automatic decode_word(input logic [31:0] w, input logic bl);
      logic [3:0]  ptype;
      logic [63:0] value;
      logic [2:0]  pos;
      int          n0;
      int          ch;
      rsp_type     tail;
      ptype = w[31:28];
      value = {36'b0, w[27:0]};
      n0 = result_q.size();
      if (discard) begin
         if (ptype == PT_TRAILER || bl) clear_frag();
         return;
      end
      if (bl && ptype != PT_TRAILER) begin
         push_result(KIND_ABORT, 0, '0, '0,
                     (ptype == PT_UNASSIGN) ? ERR_BAD_TYPE : ERR_NO_TRAILER);
         clear_frag();
      end else begin
         pos = word_pos;
         if (word_pos < 7) word_pos++;
         if (pos == 0 && !w[31]) frag_rec[F_BADFIRST] = 64'd1;
         if (opt_pending != 0 && !w[31]) begin
            if (opt_pending == 2) begin
               frag_rec[F_WFP] = {63'b0, w[15]};
               frag_rec[F_PILEUP] = {59'b0, w[4:0]};
            end else begin
               frag_rec[F_MASTER] = {32'b0, w};
            end
            opt_pending--;
            return;
         end
         opt_pending = '0;
         case (ptype)
            PT_HEADER: begin
               if (pos != 0) frag_rec[F_HDRLATE] = 64'd1;
               frag_rec[F_DTYPE] = {60'b0, w[3:0]};
               frag_rec[F_ADDR] = {48'b0, w[19:4]};
               ch = int'(w[11:4]) + 16 * int'(w[15:12]) + 256 * int'(w[19:16]);
               if (ch >= CHANNEL_COUNT) ch = CHANNEL_COUNT - 1;
               frag_rec[F_CHAN] = 64'(ch);
               pulse_count = '0;
               hdr_seen = 1'b1;
               opt_pending = 2'd2;
            end
            PT_TRIGGER: frag_rec[F_TREQ] = value;
            PT_TS_LOW: if (frag_rec[F_TS] == 0) frag_rec[F_TS] = value;
            PT_TS_HIGH: begin
               frag_rec[F_TS] = frag_rec[F_TS] | ({50'b0, w[13:0]} << 28);
               frag_rec[F_DEAD] = {50'b0, w[27:14]};
            end
            PT_WAVE: begin
               if (!hdr_seen) begin
                  frag_rec[F_WAVENOHDR] = 64'd1;
               end else if (wave_en) begin
                  push_sample(w[13:0], w[13]);
                  push_sample(w[27:14], w[27]);
               end
            end
            PT_NETWORK: begin
               frag_rec[F_NET] = sext32({32'b0, w});
               opt_pending = 2'd2;
            end
            PT_TRAILER: begin
               frag_rec[F_TACC] = {50'b0, w[27:14]};
               if (w[13:0] != frag_rec[F_TREQ][13:0] && frag_rec[F_DTYPE] != 64'hF)
                  frag_rec[F_MISMATCH] = 64'd1;
               for (int i = 0; i < NUM_FIELDS; i++)
                  push_result(KIND_FIELD, i, '0, frag_rec[i], ERR_NONE);
               clear_frag();
            end
            PT_UNASSIGN: begin
               push_result(KIND_ABORT, 0, '0, '0, ERR_BAD_TYPE);
               clear_frag();
               discard = 1'b1;
            end
            default: begin
               if (pos < 3) begin
                  frag_rec[F_WFP] = {63'b0, w[15]};
                  frag_rec[F_PILEUP] = {59'b0, w[4:0]};
                  opt_pending = 2'd1;
               end else begin
                  decode_pulse(w);
               end
            end
         endcase
      end
      if (result_q.size() > n0) begin
         tail = result_q.pop_back();
         tail.last = 1'b1;
         result_q.push_back(tail);
      end
   endtask

   // Sample both channels; predict before checking so the order is fixed.
   always @(posedge clock) begin
      rsp_type want;
      int      n0;
      req_fire = req_valid && req_ready && !reset;
      if (req_fire) begin
         n0 = result_q.size();
         decode_word(req_payload.word, req_payload.bank_last);
         if (typed_err != ERR_NONE) begin
            while (result_q.size() > n0) void'(result_q.pop_back());
            push_result(KIND_ABORT, 0, '0, '0, typed_err);
            want = result_q.pop_back();
            want.last = 1'b1;
            result_q.push_back(want);
         end
      end
      if (rsp_valid && rsp_ready && !reset) begin
         if (result_q.size() == 0) begin
            report($sformatf("unexpected result %p", rsp_payload));
         end else begin
            want = result_q.pop_front();
            if (rsp_payload.kind !== want.kind)
               report($sformatf("kind %0d want %0d", rsp_payload.kind, want.kind));
            if (rsp_payload.field_id !== want.field_id)
               report($sformatf("field_id %0d want %0d", rsp_payload.field_id,
                                want.field_id));
            if (rsp_payload.sample_index !== want.sample_index)
               report($sformatf("sample_index %0d want %0d", rsp_payload.sample_index,
                                want.sample_index));
            if (rsp_payload.field_value !== want.field_value)
               report($sformatf("field %0d value %h want %h", want.field_id,
                                rsp_payload.field_value, want.field_value));
            if (rsp_payload.error_code !== want.error_code)
               report($sformatf("error_code %0d want %0d", rsp_payload.error_code,
                                want.error_code));
            if (rsp_payload.last !== want.last)
               report($sformatf("last %0b want %0b", rsp_payload.last, want.last));
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 35);
   end

   task automatic send_word(input logic [31:0] w, input logic bl, input logic [1:0] err);
      if (!calm && $urandom_range(99) < 35) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= '{word: w, bank_last: bl};
      typed_err <= err;
      do begin
         @(posedge clock);
         #1;
      end while (!req_fire);
      words_sent++;
   endtask

   // Hold the sender until every expected result has come, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      wave_en = data[0];
   endtask

   // One fragment, mostly well formed, with random content.
   task automatic send_fragment();
      logic [31:0] trig;
      int          k;
      trig = $urandom;
      send_word({PT_HEADER, 28'($urandom)}, 1'b0, ERR_NONE);
      k = $urandom_range(2);
      repeat (k) send_word({1'b0, 31'($urandom)}, 1'b0, ERR_NONE);
      if ($urandom_range(3) == 0) begin
         send_word({PT_NETWORK, 28'($urandom)}, 1'b0, ERR_NONE);
         if ($urandom_range(1)) send_word({1'b0, 31'($urandom)}, 1'b0, ERR_NONE);
      end
      send_word({PT_TRIGGER, trig[27:0]}, 1'b0, ERR_NONE);
      send_word({PT_TS_LOW, 28'($urandom)}, 1'b0, ERR_NONE);
      send_word({PT_TS_HIGH, 28'($urandom)}, 1'b0, ERR_NONE);
      repeat ($urandom_range(3)) send_word({PT_WAVE, 28'($urandom)}, 1'b0, ERR_NONE);
      repeat ($urandom_range(9)) send_word({1'b0, 31'($urandom)}, 1'b0, ERR_NONE);
      k = $urandom_range(99);
      if (k < 4) begin
         send_word({PT_UNASSIGN, 28'($urandom)}, 1'b0, ERR_NONE);
         send_word($urandom, 1'b0, ERR_NONE);
         send_word({PT_TRAILER, 28'($urandom)}, 1'b0, ERR_NONE);
      end else if (k < 8) begin
         send_word($urandom, 1'b1, ERR_NONE);
      end else if (k < 14) begin
         repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0, ERR_NONE);
         send_word({PT_TRAILER, 28'($urandom)}, 1'($urandom_range(1)), ERR_NONE);
      end else begin
         send_word({PT_TRAILER, 14'($urandom), ($urandom_range(3) == 0) ? 14'($urandom) :
                    trig[13:0]}, $urandom_range(7) == 0, ERR_NONE);
      end
   endtask

   stim_row_type directed [] = '{
      '{32'hE000_0000, 1'b0, ERR_NONE},     // trailer straight after reset
      '{32'h8FFF_FFFF, 1'b0, ERR_NONE},     // header, channel clamped
      '{32'h0000_801F, 1'b0, ERR_NONE},
      '{32'h7FFF_FFFF, 1'b0, ERR_NONE},
      '{32'h9FFF_FFFF, 1'b0, ERR_NONE},
      '{32'hA000_0001, 1'b0, ERR_NONE},
      '{32'hA000_0002, 1'b0, ERR_NONE},     // timestamp low already set: ignored
      '{32'hBFFF_FFFF, 1'b0, ERR_NONE},
      '{32'hC800_3FFF, 1'b0, ERR_NONE},
      '{32'h7FFF_FFFF, 1'b0, ERR_NONE},
      '{32'h0000_0000, 1'b0, ERR_NONE},
      '{32'h3FFF_FFFF, 1'b0, ERR_NONE},
      '{32'h5555_AAAA, 1'b0, ERR_NONE},
      '{32'h2AAA_5555, 1'b0, ERR_NONE},
      '{32'h1234_5678, 1'b0, ERR_NONE},
      '{32'h7FFF_FFFF, 1'b0, ERR_NONE},
      '{32'h0000_0001, 1'b0, ERR_NONE},     // one pulse word too many
      '{32'hEFFF_FFFF, 1'b0, ERR_NONE},
      '{32'h8000_0016, 1'b0, ERR_NONE},     // 32-bit pulse words follow
      '{32'hDFFF_FFFF, 1'b0, ERR_NONE},
      '{32'h0000_0001, 1'b0, ERR_NONE},
      '{32'h2000_0000, 1'b0, ERR_NONE},
      '{32'h6FFF_FFFF, 1'b0, ERR_NONE},
      '{32'hE000_0005, 1'b0, ERR_NONE},     // trigger count mismatch
      '{32'hC000_0000, 1'b0, ERR_NONE},     // waveform before header
      '{32'hF000_0000, 1'b0, ERR_BAD_TYPE},
      '{32'h8000_0000, 1'b0, ERR_NONE},     // dropped while aborted
      '{32'hE000_0000, 1'b0, ERR_NONE},
      '{32'h0000_0010, 1'b0, ERR_NONE},     // bad first word
      '{32'h8000_0000, 1'b1, ERR_NO_TRAILER},
      '{32'hF123_4567, 1'b1, ERR_BAD_TYPE}
   };

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      typed_err = ERR_NONE;
      calm = 1'b0;
      req_fire = 1'b0;
      error_count = 0;
      words_sent = 0;
      wave_en = 1'b0;
      clear_frag();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_reg(3'(4 * REG_WAVEFORM_ENABLE), 32'd1);
      foreach (directed[i]) send_word(directed[i].word, directed[i].bank_last, directed[i].err);
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         write_reg(3'(4 * REG_WAVEFORM_ENABLE), (phase % 2 == 0) ? 32'd0 : 32'hFFFF_FFFF);
         calm = (phase == 2);
         while (words_sent < 20 + 100 * (phase + 1)) begin
            if ($urandom_range(9) == 0) send_word($urandom, $urandom_range(15) == 0, ERR_NONE);
            else send_fragment();
         end
         calm = 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
